### design/bba_pkg.sv
// Package for the bitmap block allocator: pool geometry, derived widths,
// transaction payload types, status and action codes, count saturation.
// No dependencies; used by bba_ffs and the top level (bba_ram does not use it).
`default_nettype none

package bba_pkg;

  // Pool geometry (BLOCK_BYTES and MAP_WORD_BITS are powers of two)
  localparam int NUM_BLOCKS    = 1024;
  localparam int BLOCK_BYTES   = 4096;
  localparam int MAP_WORD_BITS = 32;

  // Field widths
  localparam int OFFSET_W = 22;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 10;
  localparam int COUNT_MAX = 1023;

  // Derived sizes
  localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int BB_SH     = $clog2(BLOCK_BYTES);
  localparam int IDX_W     = MAP_AW + BIT_W;
  localparam int CNT_W     = $clog2(NUM_BLOCKS);

  // Request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic                action;
    logic [OFFSET_W-1:0] offset;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] block_offset;
    status_t             status;
    logic [COUNT_W-1:0]  used_count;
  } out_t;

  // Lowest-clear-bit search result for one map word
  typedef struct packed {
    logic                     full;
    logic [MAP_WORD_BITS-1:0] onehot;
    logic [BIT_W-1:0]         pos;
  } bba_ffs_t;

  // Clamp the internal count to the result field
  function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
    logic [COUNT_W-1:0] res;
    if (32'(cnt) > 32'(COUNT_MAX)) begin
      res = COUNT_W'(COUNT_MAX);
    end else begin
      res = COUNT_W'(cnt);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/bba_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/bba_ffs.sv
// Lowest-clear-bit finder for one allocation map word.
// Depends on bba_pkg.
`default_nettype none

module bba_ffs
  import bba_pkg::*;
(
  input  wire logic [MAP_WORD_BITS-1:0] word,
  output bba_ffs_t                      res
);

  logic [MAP_WORD_BITS-1:0] onehot;
  logic [BIT_W-1:0]         pos;

  // Isolate the lowest zero: carry of +1 stops at it
  assign onehot = ~word & (word + MAP_WORD_BITS'(1));

  // One-hot to binary, an OR over independent positions
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      if (onehot[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
  end

  assign res.full   = &word;
  assign res.onehot = onehot;
  assign res.pos    = pos;

endmodule

`default_nettype wire

### design/bitmap_block_allocator_unit.sv
// Bitmap first-fit block allocator, top level: sequencer, valid bits,
// used counter and output register. Depends on bba_pkg, bba_ram, bba_ffs.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request per
//   transaction: allocate (lowest free block) or free (block at offset).
//   Output channel out_valid/out_ready/out_data returns exactly one result
//   per request: byte offset, status and the used count after the request.
//   An allocate whose free block lies in map word k scans map words 0 to k
//   and then passes to the result state; the scan reads one map word per
//   cycle from the map RAM. A free passes through a write-back state and
//   then the result state; an invalid free that is rejected on its index
//   goes straight to the result state. One request is in flight at a time;
//   in_ready rises with out_valid, and a result may still wait in the output
//   register.
//   Reset (rst_n low, synchronous) clears the per-word valid bits, so the
//   map reads as all free except reserved block 0, and zeroes the count;
//   no clearing pass is needed.
//   A stalled receiver holds the finished result in the sequencer until
//   the output register frees up; the map is already updated by then.
`default_nettype none

module bitmap_block_allocator_unit
  import bba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FREE = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam logic [MAP_AW-1:0] LAST_WORD = MAP_AW'(MAP_WORDS - 1);

  state_t                   state_r, state_nxt;
  logic [MAP_AW-1:0]        word_r, word_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [MAP_WORDS-1:0]     vld_r, vld_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  out_t                     res_r, res_nxt;
  out_t                     out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Map RAM port signals
  logic                     ram_we;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic                     ram_re;
  logic [MAP_AW-1:0]        ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;

  logic [MAP_WORD_BITS-1:0] eff_word;
  bba_ffs_t                 ffs;

  // Free request decode
  logic [31:0]              free_idx;
  logic                     free_bad;
  logic [MAP_AW-1:0]        free_word;
  logic [BIT_W-1:0]         free_bit;
  logic [MAP_WORD_BITS-1:0] free_mask;

  // Allocation candidate
  logic [IDX_W-1:0]         alloc_idx;
  logic                     alloc_oob;
  logic [63:0]              alloc_prod;
  logic [CNT_W-1:0]         cnt_inc;
  logic [CNT_W-1:0]         cnt_dec;

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Never-written words read as their reset value
  always_comb begin
    if (vld_r[word_r]) begin
      eff_word = ram_rdata;
    end else if (word_r == '0) begin
      eff_word = MAP_WORD_BITS'(1);
    end else begin
      eff_word = '0;
    end
  end

  bba_ffs u_ffs (
    .word (eff_word),
    .res  (ffs)
  );

  assign free_idx  = 32'(in_data.offset >> BB_SH);
  assign free_bad  = (free_idx == 32'd0) || (free_idx >= 32'(NUM_BLOCKS));
  assign free_word = free_idx[BIT_W +: MAP_AW];
  assign free_bit  = free_idx[BIT_W-1:0];
  assign free_mask = MAP_WORD_BITS'(1) << bit_r;

  assign alloc_idx  = {word_r, ffs.pos};
  assign alloc_oob  = 32'(alloc_idx) >= 32'(NUM_BLOCKS);
  assign alloc_prod = 64'(alloc_idx) << BB_SH;
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign cnt_dec    = (cnt_r != '0) ? (cnt_r - CNT_W'(1)) : cnt_r;

  // Sequencer: one request at a time, so a write-back always lands
  // before the next read of the same word is issued
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    vld_nxt       = vld_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    ram_re        = 1'b0;
    ram_raddr     = word_r + MAP_AW'(1);
    ram_we        = 1'b0;
    ram_wdata     = eff_word;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.block_offset = '0;
          res_nxt.used_count   = sat_count(cnt_r);
          res_nxt.status       = ST_OK;
          if (in_data.action == ACT_ALLOC) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            word_nxt  = '0;
            state_nxt = S_SCAN;
          end else if (free_bad) begin
            res_nxt.status = ST_BAD_FREE;
            state_nxt      = S_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = free_word;
            word_nxt  = free_word;
            bit_nxt   = free_bit;
            state_nxt = S_FREE;
          end
        end
      end

      S_SCAN: begin
        if (!ffs.full) begin
          if (alloc_oob) begin
            res_nxt.status = ST_OOM;
          end else begin
            ram_we                = 1'b1;
            ram_wdata             = eff_word | ffs.onehot;
            vld_nxt[word_r]       = 1'b1;
            cnt_nxt               = cnt_inc;
            res_nxt.block_offset  = alloc_prod[OFFSET_W-1:0];
            res_nxt.used_count    = sat_count(cnt_inc);
          end
          state_nxt = S_FIN;
        end else if (word_r == LAST_WORD) begin
          res_nxt.status = ST_OOM;
          state_nxt      = S_FIN;
        end else begin
          // word full: fetch the next one
          ram_re   = 1'b1;
          word_nxt = word_r + MAP_AW'(1);
        end
      end

      S_FREE: begin
        if (!eff_word[bit_r]) begin
          res_nxt.status = ST_BAD_FREE;
        end else begin
          ram_we             = 1'b1;
          ram_wdata          = eff_word & ~free_mask;
          vld_nxt[word_r]    = 1'b1;
          cnt_nxt            = cnt_dec;
          res_nxt.used_count = sat_count(cnt_dec);
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
